// File: hw/rtl/bprld_pkg.sv
// ----------------------------------------------------------------------------
// bprld_pkg
// Shared types and constants for the blended pixel/rect/line drawer.
// ----------------------------------------------------------------------------
package bprld_pkg;

    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_PIXEL = 3'd1;
    localparam logic [2:0] MODE_RECT  = 3'd2;
    localparam logic [2:0] MODE_LINE  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam int          COUNT_W   = 17;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // Blend request to the shared blend unit.
    typedef struct packed {
        logic [7:0] old_val;
        logic [7:0] col;
        logic [7:0] alpha;
    } blend_req_t;

endpackage

// File: hw/rtl/bprld_ram.sv
// ----------------------------------------------------------------------------
// bprld_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bprld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/bprld_blend.sv
// ----------------------------------------------------------------------------
// bprld_blend
// One channel blend, floor((old*(255-a)+c*a)/255); one stage of registers.
// ----------------------------------------------------------------------------
module bprld_blend (
    input  logic                   clk,
    input  bprld_pkg::blend_req_t  req,
    output logic [7:0]             result
);

    logic [16:0] sum_reg;
    logic [16:0] sum_next;
    logic [25:0] prod;
    logic [7:0]  quot;
    logic [16:0] rem;

    assign sum_next = 17'({9'd0, req.old_val} * {9'd0, 8'(8'd255 - req.alpha)})
                    + 17'({9'd0, req.col} * {9'd0, req.alpha});

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // Divide by 255 via reciprocal 257/65536 with one correction step.
    assign prod = 26'(sum_reg) * 26'd257;
    assign rem  = sum_reg - 17'({9'd0, prod[23:16]} * 17'd255);
    assign quot = (rem >= 17'd255) ? (prod[23:16] + 8'd1) : prod[23:16];
    assign result = quot;

endmodule

// File: hw/rtl/bprld_div.sv
// ----------------------------------------------------------------------------
// bprld_div
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module bprld_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [23:0] num,
    input  logic signed [12:0] den,
    output logic               done,
    output logic signed [23:0] quot
);

    logic [23:0] q_reg;
    logic [23:0] q_next;
    logic [12:0] r_reg;
    logic [12:0] r_next;
    logic [12:0] d_reg;
    logic        neg_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [13:0] trial;

    assign trial = {r_reg, q_reg[23]} - {1'b0, d_reg};

    always_comb
    begin
        if (!trial[13])
        begin
            r_next = trial[12:0];
            q_next = {q_reg[22:0], 1'b1};
        end
        else
        begin
            r_next = {r_reg[11:0], q_reg[23]};
            q_next = {q_reg[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[23] ? 24'(-num) : num;
            r_reg   <= '0;
            d_reg   <= den[12] ? 13'(-den) : den;
            neg_reg <= num[23] ^ den[12];
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quot = neg_reg ? 24'(-q_reg) : q_reg;

endmodule

// File: hw/rtl/blended_pixel_rect_line_drawer.sv
// ----------------------------------------------------------------------------
// blended_pixel_rect_line_drawer
// Each blended point takes the steps check, RAM read, three passes through
// the shared blend unit and write; an out-of-frame point takes check and
// write only. A line adds one end test per point and one at the end; a
// diagonal line point adds the serial y divide. One command at a time:
// busy is high until the result strobe, which the receiver cannot stall.
// Reset (rst_n, async) clears control only; frame contents are undefined.
// ----------------------------------------------------------------------------
module blended_pixel_rect_line_drawer #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic signed [10:0] x_a,
    input  logic signed [10:0] y_a,
    input  logic signed [10:0] x_b,
    input  logic signed [10:0] y_b,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    output logic               done,
    output logic [7:0]         pixel_red,
    output logic [7:0]         pixel_green,
    output logic [7:0]         pixel_blue,
    output logic [7:0]         pixel_alpha,
    output logic [16:0]        pixels_written,
    output logic               clipped
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_NEXT, S_DIV, S_DIVW, S_CHECK, S_RD, S_BL0,
        S_WR, S_RDOUT, S_DONE
    } state_t;

    state_t state_reg;

    // Request registers.
    logic [2:0]         mode_reg;
    logic signed [12:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [7:0]         r_reg, g_reg, b_reg, a_reg;

    // Walk registers: current point, inner rectangle counters.
    logic signed [12:0] cx_reg, cy_reg;
    logic signed [12:0] w_reg, h_reg;
    logic signed [12:0] step_reg;
    logic               axis_y_reg;   // line steps along y
    logic               diag_reg;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      addr_reg;
    logic [16:0]        cnt_reg;
    logic               clip_reg;
    logic [31:0]        rdout_reg;
    logic [7:0]         nr_reg, ng_reg;

    // RAM port.
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    bprld_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared blend unit, one channel per cycle.
    bprld_pkg::blend_req_t blend_req;
    logic [7:0]            blend_out;
    logic [1:0]            ch_reg;

    bprld_blend u_blend (
        .clk    (clk),
        .req    (blend_req),
        .result (blend_out)
    );

    always_comb
    begin
        blend_req.alpha = a_reg;
        case (ch_reg)
            2'd0:
            begin
                blend_req.old_val = ram_rdata[7:0];
                blend_req.col     = r_reg;
            end
            2'd1:
            begin
                blend_req.old_val = ram_rdata[15:8];
                blend_req.col     = g_reg;
            end
            default:
            begin
                blend_req.old_val = ram_rdata[23:16];
                blend_req.col     = b_reg;
            end
        endcase
    end

    // Divider for diagonal line y.
    logic               div_start;
    logic               div_done;
    logic signed [23:0] div_num;
    logic signed [23:0] div_q;
    logic signed [12:0] dx_s, dy_s;

    assign dx_s = xb_reg - xa_reg;
    assign dy_s = yb_reg - ya_reg;
    // operands sign-extended to 24 bits; |num| stays below 2^23
    assign div_num = 24'(ya_reg) * 24'(dx_s) + 24'(dy_s) * 24'(cx_reg - xa_reg);

    bprld_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dx_s),
        .done  (div_done),
        .quot  (div_q)
    );

    assign div_start = (state_reg == S_DIV);

    // Point in frame and its address.
    logic in_frame;
    assign in_frame = !cx_reg[12] && (cx_reg < 13'(FRAME_WIDTH))
                   && !cy_reg[12] && (cy_reg < 13'(FRAME_HEIGHT));
    logic [AW-1:0] pt_addr;
    assign pt_addr = AW'(32'(cy_reg) * FRAME_WIDTH + 32'(cx_reg));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = {a_reg, blend_out, ng_reg, nr_reg};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = {a_reg, b_reg, g_reg, r_reg};
            end
            S_WR:
            begin
                // out-of-frame points are dropped
                ram_we = in_frame;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // Remaining walk: has the current point reached its end?
    logic walk_end;
    always_comb
    begin
        case (mode_reg)
            bprld_pkg::MODE_RECT: walk_end = (h_reg >= yb_reg);
            bprld_pkg::MODE_LINE: walk_end = axis_y_reg ? (cy_reg == yb_reg)
                                                        : (cx_reg == xb_reg);
            default:              walk_end = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            cnt_reg   <= '0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg  <= mode;
                        xa_reg    <= 13'(x_a);
                        ya_reg    <= 13'(y_a);
                        xb_reg    <= 13'(x_b);
                        yb_reg    <= 13'(y_b);
                        r_reg     <= red;
                        g_reg     <= green;
                        b_reg     <= blue;
                        a_reg     <= alpha;
                        cx_reg    <= 13'(x_a);
                        cy_reg    <= 13'(y_a);
                        w_reg     <= '0;
                        h_reg     <= '0;
                        clr_reg   <= '0;
                        cnt_reg   <= '0;
                        clip_reg  <= 1'b0;
                        rdout_reg <= '0;
                        axis_y_reg <= (x_b == x_a);
                        diag_reg   <= (x_b != x_a) && (y_b != y_a);
                        if (x_b == x_a)
                            step_reg <= (y_b > y_a) ? 13'sd1 : -13'sd1;
                        else
                            step_reg <= (x_b > x_a) ? 13'sd1 : -13'sd1;
                        case (mode)
                            bprld_pkg::MODE_CLEAR: state_reg <= S_CLEAR;
                            bprld_pkg::MODE_PIXEL: state_reg <= S_CHECK;
                            bprld_pkg::MODE_RECT:
                                state_reg <= (x_b > 0 && y_b > 0) ? S_CHECK : S_DONE;
                            bprld_pkg::MODE_LINE:
                                state_reg <= S_NEXT;
                            bprld_pkg::MODE_READ:  state_reg <= S_CHECK;
                            default:               state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (cnt_reg != bprld_pkg::COUNT_MAX)
                        cnt_reg <= cnt_reg + 17'd1;
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_DONE;
                end
                S_NEXT:
                begin
                    // Line: test end, then place the point.
                    if (walk_end)
                        state_reg <= S_DONE;
                    else if (diag_reg)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_CHECK;
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        cy_reg    <= 13'(div_q);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    addr_reg <= pt_addr;
                    if (in_frame)
                        state_reg <= (mode_reg == bprld_pkg::MODE_READ) ? S_RDOUT : S_RD;
                    else
                    begin
                        clip_reg  <= 1'b1;
                        state_reg <= S_WR;
                    end
                    ch_reg <= 2'd0;
                end
                S_RD:
                begin
                    // RAM read data valid next cycle.
                    state_reg <= S_BL0;
                end
                S_BL0:
                begin
                    // blend result is registered and arrives in the cycle after its request
                    ch_reg <= ch_reg + 2'd1;
                    if (ch_reg == 2'd1)
                        nr_reg <= blend_out;
                    if (ch_reg == 2'd2)
                    begin
                        ng_reg    <= blend_out;
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    // Write happens here when in frame; otherwise skip.
                    if (in_frame)
                    begin
                        if (cnt_reg != bprld_pkg::COUNT_MAX)
                            cnt_reg <= cnt_reg + 17'd1;
                    end
                    case (mode_reg)
                        bprld_pkg::MODE_RECT:
                        begin
                            if (w_reg + 13'sd1 < xb_reg)
                            begin
                                w_reg  <= w_reg + 13'sd1;
                                cx_reg <= cx_reg + 13'sd1;
                                state_reg <= S_CHECK;
                            end
                            else if (h_reg + 13'sd1 < yb_reg)
                            begin
                                w_reg  <= '0;
                                h_reg  <= h_reg + 13'sd1;
                                cx_reg <= xa_reg;
                                cy_reg <= cy_reg + 13'sd1;
                                state_reg <= S_CHECK;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        bprld_pkg::MODE_LINE:
                        begin
                            if (axis_y_reg)
                                cy_reg <= cy_reg + step_reg;
                            else
                                cx_reg <= cx_reg + step_reg;
                            state_reg <= S_NEXT;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_RDOUT:
                begin
                    state_reg <= S_DONE;
                    rdout_reg <= '0;
                end
                S_DONE:
                begin
                    if (mode_reg == bprld_pkg::MODE_READ && !clip_reg)
                        rdout_reg <= ram_rdata;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pixel_red      = done ? rdout_reg[7:0]   : 8'd0;
    assign pixel_green    = done ? rdout_reg[15:8]  : 8'd0;
    assign pixel_blue     = done ? rdout_reg[23:16] : 8'd0;
    assign pixel_alpha    = done ? rdout_reg[31:24] : 8'd0;
    assign pixels_written = cnt_reg;
    assign clipped        = clip_reg;

endmodule
